// ===== rtl/core/tws_pkg.sv =====
// Shared codes and controller/datapath interface types for the trie word store.
package tws_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_PREFIX = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam logic [6:0] LETTER_BASE = 7'd97;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic commit;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic item_last;
    } t_dp_sts;

endpackage

// ===== rtl/core/tws_ctrl.sv =====
// Sequencer for the trie word store: clearing pass, word load, row update, output valid.
module tws_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tws_pkg::t_dp_sts  i_sts,
    output tws_pkg::t_ctl_cmd o_cmd
);
    import tws_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

    assign o_cmd.clr_step = (r_state == S_CLEAR);
    assign o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
    // a last word waits here until the output register can take its result
    assign o_cmd.commit   = (r_state == S_EXEC) && (!i_sts.item_last || out_free);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                    if (i_sts.item_last) n_out_valid = 1'b1;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/tws_dp.sv =====
// Datapath of the trie word store: node row memory, walk registers, result register.
module tws_dp #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tws_pkg::t_ctl_cmd i_cmd,
    output tws_pkg::t_dp_sts  o_sts,
    input  logic [1:0]        i_op,
    input  logic [6:0]        i_letter,
    input  logic              i_last,
    output logic              o_found,
    output logic [1:0]        o_status
);
    import tws_pkg::*;

    localparam int IDXW = $clog2(NODE_COUNT);
    localparam int SLW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int FW   = IDXW + 1;
    localparam logic [FW-1:0]   POOL_END = FW'(NODE_COUNT);
    localparam logic [IDXW-1:0] CLR_END  = IDXW'(NODE_COUNT - 1);
    localparam logic [6:0]      SLOT_END = 7'(ALPHABET_SIZE);

    // one row per node; each slot holds the child link and the child's word mark on top
    typedef logic [ALPHABET_SIZE-1:0][IDXW:0] t_row;

    t_row mem [NODE_COUNT];

    t_row              r_row;
    logic [1:0]        r_op;
    logic [6:0]        r_letter;
    logic              r_last;
    logic [IDXW-1:0]   r_cur, n_cur;
    logic [FW-1:0]     r_free, n_free;
    logic              r_miss, n_miss;
    logic              r_ovf, n_ovf;
    logic [IDXW-1:0]   r_clr;
    logic              r_found, n_found;
    logic [1:0]        r_status, n_status;

    logic [6:0]        slot_off;
    logic              letter_ok;
    logic [SLW-1:0]    slot;
    logic [IDXW:0]     entry, new_entry;
    logic              alloc, mark_wr, wr_en;
    t_row              wr_row;

    assign o_sts.clr_done  = (r_clr == CLR_END);
    assign o_sts.item_last = r_last;
    assign o_found         = r_found;
    assign o_status        = r_status;

    always_comb begin
        slot_off  = r_letter - LETTER_BASE;
        letter_ok = (r_letter >= LETTER_BASE) && (slot_off < SLOT_END);
        slot      = slot_off[SLW-1:0];
        entry     = r_row[slot];
        new_entry = entry;
        n_cur     = r_cur;
        n_miss    = r_miss;
        n_ovf     = r_ovf;
        n_free    = r_free;
        alloc     = 1'b0;
        mark_wr   = 1'b0;
        n_found   = 1'b0;
        n_status  = ST_OK;

        // skip the rest of a broken word
        if (!(r_miss || r_ovf)) begin
            if (!letter_ok) begin
                n_miss = 1'b1;
            end else if (entry[IDXW-1:0] != '0) begin
                n_cur = entry[IDXW-1:0];
            end else if (r_op != OP_INSERT) begin
                n_miss = 1'b1;
            end else if (r_free >= POOL_END) begin
                n_ovf = 1'b1;
            end else begin
                alloc     = 1'b1;
                new_entry = {1'b0, r_free[IDXW-1:0]};
                n_cur     = r_free[IDXW-1:0];
                n_free    = r_free + 1'b1;
            end
        end

        if (r_last) begin
            if (r_op == OP_INSERT) begin
                if (n_ovf) begin
                    n_status = ST_FULL;
                end else if (n_miss) begin
                    n_status = ST_MISSING;
                end else begin
                    new_entry[IDXW] = 1'b1;
                    mark_wr         = 1'b1;
                end
            end else if (n_miss || n_ovf) begin
                n_status = ST_MISSING;
            end else begin
                case (r_op)
                    OP_SEARCH: n_found = new_entry[IDXW];
                    OP_PREFIX: n_found = 1'b1;
                    OP_REMOVE: begin
                        new_entry[IDXW] = 1'b0;
                        mark_wr         = 1'b1;
                    end
                    default: n_found = 1'b0;
                endcase
            end
        end

        wr_row       = r_row;
        wr_row[slot] = new_entry;
        wr_en        = i_cmd.commit && (alloc || mark_wr);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr] <= '0;
        end else if (wr_en) begin
            mem[r_cur] <= wr_row;
        end
        if (i_cmd.load) begin
            r_row    <= mem[r_cur];
            r_op     <= i_op;
            r_letter <= i_letter;
            r_last   <= i_last;
        end
        if (i_cmd.commit && r_last) begin
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_free <= FW'(1);
            r_miss <= 1'b0;
            r_ovf  <= 1'b0;
            r_clr  <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.commit) begin
                // return to the root after the last word
                r_cur  <= r_last ? '0 : n_cur;
                r_miss <= r_last ? 1'b0 : n_miss;
                r_ovf  <= r_last ? 1'b0 : n_ovf;
                r_free <= n_free;
            end
        end
    end

endmodule

// ===== rtl/core/trie_word_store_core.sv =====
// Top level of the trie word store: stream ports around controller and datapath.
//
// Input stream: one word per letter of a lower-case key. tuser carries the
// operation (insert, exact search, prefix check, remove), tdata the letter
// code, tlast marks the final letter. Only a final letter yields a result
// word: tdata holds found and a status code (ok, pool full, path missing).
// For each letter the accept cycle reads the current node's row from the
// node memory, and the next cycle follows or creates the child link and
// writes the row back through the single memory port. The result appears in
// the output register in the cycle after the last letter's update cycle.
// The output register lets the next key start while a result waits; a final
// letter holds in its update cycle while the previous result is not taken.
// After reset a clearing pass writes every node row to zero, one row per
// cycle, with s_axis_tready low. Nodes are never freed; once the pool is
// exhausted inserts that need a new node report pool full.
module trie_word_store_core #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [6:0] letter, [7] zero
    input  logic [1:0] s_axis_tuser,   // [1:0] cmd
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] found, [2:1] status, [7:3] zero
);
    import tws_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_sts    sts;
    logic       found;
    logic [1:0] status;

    tws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tws_dp #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_op     (s_axis_tuser),
        .i_letter (s_axis_tdata[6:0]),
        .i_last   (s_axis_tlast),
        .o_found  (found),
        .o_status (status)
    );

    assign m_axis_tdata = {5'b0, status, found};

endmodule

// ===== rtl/core/tws_checker.sv =====
// Port-level assertions for the trie word store, bound to the top level.
module tws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import tws_pkg::*;

    // a letter blocks the input for its update cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    // a new result is only loaded from an update cycle
    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid ##1 m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an update cycle");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

    // found is only reported with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] == ST_OK))
        else $error("found set with a failing status");

endmodule

bind trie_word_store_core tws_checker u_tws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
